>>> sv/cpe_pkg.sv
// Shared types, constants and lookup functions for the cart-pole Euler step block.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package cpe_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
   localparam int CRD_BITS  = 34;
   localparam int CRD_ITERS = 30;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS-1:0]        umag_type;

   // Fixed-point constants, rounded half up to Q16.16.
   localparam word_type K_PL_VAL    = 32'sd3277;    // 0.05 (pole mass times half length)
   localparam word_type K_TM_VAL    = 32'sd72090;   // 1.1 total mass
   localparam word_type K_TAU_VAL   = 32'sd1311;    // 0.02 time step
   localparam word_type K_G_VAL     = 32'sd642253;  // 9.8 gravity
   localparam word_type K_PM_VAL    = 32'sd6554;    // 0.1 pole mass
   localparam word_type K_HALF_VAL  = 32'sd32768;   // 0.5 half length
   localparam word_type K_FOUR3_VAL = 32'sd87381;   // 1.3333333

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // Range reduction: quarter turn in Q16.16 and an offset of 32768 quarter turns
   // that keeps the dividend positive for any angle.
   localparam logic [16:0] HALF_PI_Q = 17'd102944;
   localparam logic [16:0] HALF_H    = 17'd51472;
   localparam logic [33:0] RED_OFS   = 34'd3373268992;
   localparam logic signed [CRD_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_REDUCE,
      SQ_CORDIC,
      SQ_ROUND,
      SQ_ISSUE,
      SQ_WAIT,
      SQ_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [4:0] {
      R_POS, R_VEL, R_ANG, R_RATE, R_S, R_C, R_T, R_TEMP, R_NUMR, R_DEN,
      R_TACC, R_XACC, R_FORCE,
      K_PL, K_TM, K_TAU, K_G, K_PM, K_HALF, K_FOUR3
   } opnd_type;

   typedef struct packed {
      op_type   op;
      opnd_type a;
      opnd_type b;
      opnd_type dst;
   } instr_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      umag_type            divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quot;
      umag_type            rem;
   } div_rsp_type;

   typedef struct packed {
      word_type position;
      word_type velocity;
      word_type angle;
      word_type angular_rate;
   } init_type;

   typedef struct packed {
      word_type position;
      word_type velocity;
      word_type angle;
      word_type angular_rate;
      logic     saturated;
   } result_type;

   typedef struct packed {
      logic start;
      logic action;
      logic take;
   } seq_ctl_type;

   localparam logic [4:0] PROG_LAST = 5'd25;

   function automatic instr_type prog(input logic [4:0] pc);
      instr_type i;
      i = '{OP_ADD, R_T, R_T, R_T};
      unique case (pc)
         5'd0:  i = '{OP_MUL, K_PL,    R_RATE, R_T};
         5'd1:  i = '{OP_MUL, R_T,     R_RATE, R_T};
         5'd2:  i = '{OP_MUL, R_T,     R_S,    R_T};
         5'd3:  i = '{OP_ADD, R_FORCE, R_T,    R_T};
         5'd4:  i = '{OP_DIV, R_T,     K_TM,   R_TEMP};
         5'd5:  i = '{OP_MUL, K_G,     R_S,    R_NUMR};
         5'd6:  i = '{OP_MUL, R_C,     R_TEMP, R_T};
         5'd7:  i = '{OP_SUB, R_NUMR,  R_T,    R_NUMR};
         5'd8:  i = '{OP_MUL, K_PM,    R_C,    R_DEN};
         5'd9:  i = '{OP_MUL, R_DEN,   R_C,    R_DEN};
         5'd10: i = '{OP_DIV, R_DEN,   K_TM,   R_DEN};
         5'd11: i = '{OP_SUB, K_FOUR3, R_DEN,  R_DEN};
         5'd12: i = '{OP_MUL, K_HALF,  R_DEN,  R_DEN};
         5'd13: i = '{OP_DIV, R_NUMR,  R_DEN,  R_TACC};
         5'd14: i = '{OP_MUL, K_PL,    R_TACC, R_T};
         5'd15: i = '{OP_MUL, R_T,     R_C,    R_T};
         5'd16: i = '{OP_DIV, R_T,     K_TM,   R_T};
         5'd17: i = '{OP_SUB, R_TEMP,  R_T,    R_XACC};
         5'd18: i = '{OP_MUL, K_TAU,   R_VEL,  R_T};
         5'd19: i = '{OP_ADD, R_POS,   R_T,    R_POS};
         5'd20: i = '{OP_MUL, K_TAU,   R_XACC, R_T};
         5'd21: i = '{OP_ADD, R_VEL,   R_T,    R_VEL};
         5'd22: i = '{OP_MUL, K_TAU,   R_RATE, R_T};
         5'd23: i = '{OP_ADD, R_ANG,   R_T,    R_ANG};
         5'd24: i = '{OP_MUL, K_TAU,   R_TACC, R_T};
         5'd25: i = '{OP_ADD, R_RATE,  R_T,    R_RATE};
         default: i = '{OP_ADD, R_T, R_T, R_T};
      endcase
      return i;
   endfunction

   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      v = 32'd0;
      unique case (i)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048575;
         5'd11: v = 32'd524287;
         5'd12: v = 32'd262143;
         5'd13: v = 32'd131071;
         5'd14: v = 32'd65535;
         5'd15: v = 32'd32767;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         5'd24: v = 32'd64;
         5'd25: v = 32'd32;
         5'd26: v = 32'd16;
         5'd27: v = 32'd8;
         5'd28: v = 32'd4;
         5'd29: v = 32'd2;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic umag_type mag(input word_type v);
      word_type n;
      n = -v;
      return v[WORD_BITS-1] ? umag_type'(n) : umag_type'(v);
   endfunction

endpackage

>>> sv/cpe_if.sv
// Valid/ready channel interfaces for step requests and state responses.
// Depends on cpe_pkg for the word type.
`timescale 1ns / 1ps

interface cpe_req_if;
   logic              valid;
   logic              ready;
   logic              action;
   cpe_pkg::word_type force_req;

   modport source (output valid, action, force_req, input ready);
   modport sink (input valid, action, force_req, output ready);
endinterface

interface cpe_rsp_if;
   logic              valid;
   logic              ready;
   cpe_pkg::word_type position;
   cpe_pkg::word_type velocity;
   cpe_pkg::word_type angle;
   cpe_pkg::word_type angular_rate;
   logic              saturated;

   modport source (output valid, position, velocity, angle, angular_rate, saturated,
                   input ready);
   modport sink (input valid, position, velocity, angle, angular_rate, saturated,
                 output ready);
endinterface

>>> sv/cpe_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle over a 48-bit dividend.
// Depends on cpe_pkg for the request and response structs.
`timescale 1ns / 1ps

module cpe_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cpe_pkg::div_req_type req,
   output cpe_pkg::div_rsp_type rsp
);
   import cpe_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   umag_type            rem_ff, rem_in;
   umag_type            dvs_ff, dvs_in;
   logic [WORD_BITS:0]  trial;
   logic [WORD_BITS:0]  diff;
   logic                ge;

   assign trial = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DIV_BITS - 1);
         dvd_in  = req.dividend;
         quo_in  = '0;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         rem_in = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> sv/cpe_multiplier.sv
// Registered 32x32 magnitude multiplier with Q16.16 rounding and clamping.
// Depends on cpe_pkg for word types and the mag function.
`timescale 1ns / 1ps

module cpe_multiplier (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cpe_pkg::word_type op_a,
   input  cpe_pkg::word_type op_b,
   output logic              done,
   output cpe_pkg::word_type result,
   output logic              sat
);
   import cpe_pkg::*;

   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int RL_BITS   = PROD_BITS - FRAC_BITS + 1;

   logic [PROD_BITS-1:0] prod_ff;
   logic                 neg_ff;
   logic                 done_ff;
   logic [PROD_BITS:0]   rnd;
   logic [RL_BITS-1:0]   rl;
   logic [RL_BITS-1:0]   lim;
   logic [RL_BITS-1:0]   m;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      if (start) begin
         prod_ff <= mag(op_a) * mag(op_b);
         neg_ff  <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
      end
   end

   // Round the magnitude half away from zero, then clamp to the signed range.
   assign rnd = {1'b0, prod_ff} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
   assign rl  = rnd[PROD_BITS:FRAC_BITS];
   assign lim = neg_ff ? RL_BITS'(1) << (WORD_BITS - 1)
                       : (RL_BITS'(1) << (WORD_BITS - 1)) - RL_BITS'(1);
   assign sat = rl > lim;
   assign m   = sat ? lim : rl;

   assign result = neg_ff ? -word_type'(m[WORD_BITS-1:0]) : word_type'(m[WORD_BITS-1:0]);
   assign done   = done_ff;

endmodule

>>> sv/cpe_sequencer.sv
// Step sequencer: angle reduction, CORDIC sine/cosine and the dynamics program.
// Depends on cpe_pkg, cpe_divider and cpe_multiplier.
`timescale 1ns / 1ps

module cpe_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  cpe_pkg::seq_ctl_type ctl,
   input  cpe_pkg::word_type    force_req,
   input  cpe_pkg::init_type    init,
   output logic                 idle,
   output logic                 done,
   output cpe_pkg::result_type  result
);
   import cpe_pkg::*;

   seq_state_type state_ff, state_in;

   word_type pos_ff, pos_in, vel_ff, vel_in, ang_ff, ang_in, rate_ff, rate_in;
   word_type s_ff, s_in, c_ff, c_in, t_ff, t_in, temp_ff, temp_in;
   word_type numr_ff, numr_in, den_ff, den_in, tacc_ff, tacc_in, xacc_ff, xacc_in;
   word_type force_ff, force_in;
   logic     sat_ff, sat_in;
   logic [4:0] pc_ff, pc_in;
   logic [4:0] iter_ff, iter_in;
   logic [1:0] quad_ff, quad_in;
   logic signed [CRD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   instr_type   instr;
   word_type    opa, opb;
   div_req_type dreq;
   div_rsp_type drsp;
   logic        mul_start, mul_done, mul_sat;
   word_type    mul_res;

   // Write-back path shared by every program step.
   logic        wr_en;
   word_type    wr_val;
   logic        wr_sat;
   logic        step_done;

   logic signed [WORD_BITS:0] sum;
   logic [33:0]               red_u;
   logic signed [17:0]        red_r;
   logic signed [CRD_BITS-1:0] cdx, cdy, cat;
   logic signed [CRD_BITS-1:0] s_rnd, c_rnd;
   word_type                  s0, c0;

   logic                      dneg, dzero, dround, dsat;
   umag_type                  dma, dmb;
   logic [DIV_BITS:0]         dq, dlim, dm;

   function automatic word_type pick(input opnd_type o, input word_type p, input word_type v,
                                     input word_type a, input word_type r, input word_type s,
                                     input word_type c, input word_type t, input word_type tm,
                                     input word_type nu, input word_type de, input word_type ta,
                                     input word_type xa, input word_type fo);
      word_type x;
      x = '0;
      case (o)
         R_POS:   x = p;
         R_VEL:   x = v;
         R_ANG:   x = a;
         R_RATE:  x = r;
         R_S:     x = s;
         R_C:     x = c;
         R_T:     x = t;
         R_TEMP:  x = tm;
         R_NUMR:  x = nu;
         R_DEN:   x = de;
         R_TACC:  x = ta;
         R_XACC:  x = xa;
         R_FORCE: x = fo;
         K_PL:    x = K_PL_VAL;
         K_TM:    x = K_TM_VAL;
         K_TAU:   x = K_TAU_VAL;
         K_G:     x = K_G_VAL;
         K_PM:    x = K_PM_VAL;
         K_HALF:  x = K_HALF_VAL;
         K_FOUR3: x = K_FOUR3_VAL;
         default: x = '0;
      endcase
      return x;
   endfunction

   assign instr = prog(pc_ff);
   assign opa = pick(instr.a, pos_ff, vel_ff, ang_ff, rate_ff, s_ff, c_ff, t_ff, temp_ff,
                     numr_ff, den_ff, tacc_ff, xacc_ff, force_ff);
   assign opb = pick(instr.b, pos_ff, vel_ff, ang_ff, rate_ff, s_ff, c_ff, t_ff, temp_ff,
                     numr_ff, den_ff, tacc_ff, xacc_ff, force_ff);

   cpe_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   cpe_multiplier u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (opa),
      .op_b   (opb),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   // Range reduction dividend: angle plus half a quarter turn plus a positive offset.
   assign red_u = {{2{ang_ff[WORD_BITS-1]}}, ang_ff} + {17'd0, HALF_H} + RED_OFS;
   assign red_r = signed'({1'b0, drsp.rem[16:0]}) - signed'({1'b0, HALF_H});

   assign cdx = cy_ff >>> iter_ff;
   assign cdy = cx_ff >>> iter_ff;
   assign cat = signed'({2'b00, atan_q30(iter_ff)});

   assign s_rnd = (cy_ff + CRD_BITS'(signed'(8192))) >>> (30 - FRAC_BITS);
   assign c_rnd = (cx_ff + CRD_BITS'(signed'(8192))) >>> (30 - FRAC_BITS);
   assign s0 = s_rnd[WORD_BITS-1:0];
   assign c0 = c_rnd[WORD_BITS-1:0];

   // Signed division result from the unsigned quotient.
   assign dma   = mag(opa);
   assign dmb   = mag(opb);
   assign dneg  = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
   assign dzero = (opb == '0);
   assign dround = {drsp.rem, 1'b0} >= {1'b0, dmb};
   assign dq    = {1'b0, drsp.quot} + (DIV_BITS+1)'(dround);
   assign dlim  = dneg ? (DIV_BITS+1)'(1) << (WORD_BITS - 1)
                       : ((DIV_BITS+1)'(1) << (WORD_BITS - 1)) - (DIV_BITS+1)'(1);
   assign dsat  = dq > dlim;
   assign dm    = dsat ? dlim : dq;

   assign sum = (instr.op == OP_SUB) ? {opa[WORD_BITS-1], opa} - {opb[WORD_BITS-1], opb}
                                     : {opa[WORD_BITS-1], opa} + {opb[WORD_BITS-1], opb};

   always_comb begin
      wr_en  = 1'b0;
      wr_val = '0;
      wr_sat = 1'b0;
      if (state_ff == SQ_ISSUE) begin
         unique case (instr.op)
            OP_ADD, OP_SUB: begin
               wr_en  = 1'b1;
               wr_sat = sum[WORD_BITS] != sum[WORD_BITS-1];
               wr_val = wr_sat ? (sum[WORD_BITS] ? WORD_MIN : WORD_MAX) : sum[WORD_BITS-1:0];
            end
            OP_DIV: begin
               if (dzero) begin
                  wr_en  = 1'b1;
                  wr_sat = 1'b1;
                  wr_val = opa[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
               end
            end
            OP_MUL: ;
         endcase
      end else if (state_ff == SQ_WAIT) begin
         if (instr.op == OP_MUL && mul_done) begin
            wr_en  = 1'b1;
            wr_sat = mul_sat;
            wr_val = mul_res;
         end else if (instr.op == OP_DIV && drsp.done) begin
            wr_en  = 1'b1;
            wr_sat = dsat;
            wr_val = dneg ? -word_type'(dm[WORD_BITS-1:0]) : word_type'(dm[WORD_BITS-1:0]);
         end
      end
   end

   assign step_done = wr_en && (pc_ff == PROG_LAST);
   assign mul_start = (state_ff == SQ_ISSUE) && (instr.op == OP_MUL);

   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = {DIV_BITS{1'b0}};
      dreq.divisor  = dmb;
      if (state_ff == SQ_IDLE) begin
         dreq.start    = ctl.start && !ctl.action;
         dreq.dividend = DIV_BITS'(red_u);
         dreq.divisor  = umag_type'(HALF_PI_Q);
      end else if (state_ff == SQ_ISSUE) begin
         dreq.start    = (instr.op == OP_DIV) && !dzero;
         dreq.dividend = {dma, {FRAC_BITS{1'b0}}};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (ctl.start) begin
               state_in = ctl.action ? SQ_DONE : SQ_REDUCE;
            end
         end
         SQ_REDUCE: begin
            if (drsp.done) begin
               state_in = SQ_CORDIC;
            end
         end
         SQ_CORDIC: begin
            if (iter_ff == 5'(CRD_ITERS - 1)) begin
               state_in = SQ_ROUND;
            end
         end
         SQ_ROUND: state_in = SQ_ISSUE;
         SQ_ISSUE: begin
            if (step_done) begin
               state_in = SQ_DONE;
            end else if (!wr_en) begin
               state_in = SQ_WAIT;
            end
         end
         SQ_WAIT: begin
            if (step_done) begin
               state_in = SQ_DONE;
            end else if (wr_en) begin
               state_in = SQ_ISSUE;
            end
         end
         SQ_DONE: begin
            if (ctl.take) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      pos_in = pos_ff;  vel_in = vel_ff;  ang_in = ang_ff;  rate_in = rate_ff;
      s_in = s_ff;      c_in = c_ff;      t_in = t_ff;      temp_in = temp_ff;
      numr_in = numr_ff; den_in = den_ff; tacc_in = tacc_ff; xacc_in = xacc_ff;
      force_in = force_ff;
      sat_in  = sat_ff;
      pc_in   = pc_ff;
      iter_in = iter_ff;
      quad_in = quad_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (ctl.start) begin
               sat_in   = 1'b0;
               force_in = force_req;
               if (ctl.action) begin
                  pos_in  = init.position;
                  vel_in  = init.velocity;
                  ang_in  = init.angle;
                  rate_in = init.angular_rate;
               end
            end
         end
         SQ_REDUCE: begin
            quad_in = drsp.quot[1:0];
            iter_in = '0;
            cx_in   = CORDIC_GAIN;
            cy_in   = '0;
            cz_in   = CRD_BITS'(red_r) <<< (30 - FRAC_BITS);
         end
         SQ_CORDIC: begin
            if (!cz_ff[CRD_BITS-1]) begin
               cx_in = cx_ff - cdx;
               cy_in = cy_ff + cdy;
               cz_in = cz_ff - cat;
            end else begin
               cx_in = cx_ff + cdx;
               cy_in = cy_ff - cdy;
               cz_in = cz_ff + cat;
            end
            iter_in = iter_ff + 5'd1;
         end
         SQ_ROUND: begin
            pc_in = '0;
            unique case (quad_ff)
               2'd0: begin s_in = s0;  c_in = c0;  end
               2'd1: begin s_in = c0;  c_in = -s0; end
               2'd2: begin s_in = -s0; c_in = -c0; end
               2'd3: begin s_in = -c0; c_in = s0;  end
            endcase
         end
         SQ_ISSUE, SQ_WAIT: begin
            if (wr_en) begin
               sat_in = sat_ff | wr_sat;
               pc_in  = pc_ff + 5'd1;
               case (instr.dst)
                  R_POS:   pos_in  = wr_val;
                  R_VEL:   vel_in  = wr_val;
                  R_ANG:   ang_in  = wr_val;
                  R_RATE:  rate_in = wr_val;
                  R_S:     s_in    = wr_val;
                  R_C:     c_in    = wr_val;
                  R_T:     t_in    = wr_val;
                  R_TEMP:  temp_in = wr_val;
                  R_NUMR:  numr_in = wr_val;
                  R_DEN:   den_in  = wr_val;
                  R_TACC:  tacc_in = wr_val;
                  R_XACC:  xacc_in = wr_val;
                  default: force_in = force_ff;
               endcase
            end
         end
         SQ_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         pos_ff   <= '0;
         vel_ff   <= '0;
         ang_ff   <= '0;
         rate_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         ang_ff   <= ang_in;
         rate_ff  <= rate_in;
         sat_ff   <= sat_in;
      end
      s_ff <= s_in;       c_ff <= c_in;       t_ff <= t_in;       temp_ff <= temp_in;
      numr_ff <= numr_in; den_ff <= den_in;   tacc_ff <= tacc_in; xacc_ff <= xacc_in;
      force_ff <= force_in;
      pc_ff <= pc_in;
      iter_ff <= iter_in;
      quad_ff <= quad_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;
   end

   assign idle = (state_ff == SQ_IDLE);
   assign done = (state_ff == SQ_DONE);
   assign result.position     = pos_ff;
   assign result.velocity     = vel_ff;
   assign result.angle        = ang_ff;
   assign result.angular_rate = rate_ff;
   assign result.saturated    = sat_ff;

endmodule

>>> sv/cartpole_euler_step.sv
// Cart-pole simulator, one explicit Euler step per step request word.
//
// Usage: a request word on req_if carries action and force_req. Action 0 advances the
// state by one 0.02 s step under the given force; action 1 loads the four initial
// values from the configuration registers. Every request gives exactly one response
// word on rsp_if with the new position, velocity, angle, angular rate and a flag that
// is set when any operation of the step clamped to the Q16.16 range.
// The configuration port is APB style with registers at byte addresses 0, 4, 8 and 12
// (initial position, velocity, angle, angular rate); pready is always high and the
// registers read back. Write them only while no request is in flight.
// Step time is set mostly by the radix-2 divider and its five uses (range reduction of
// the angle and four divides of the dynamics), plus 30 CORDIC rotations and fourteen
// multiplies. One request is worked on at a time; the request channel is ready only
// while the sequencer is idle.
// The response sits in an output register, so the block accepts the next request as
// soon as the current result has moved there, even while the receiver stalls; a
// further result waits inside until that register is free.
// Reset is synchronous and clears the state, the registers and both channels.
`timescale 1ns / 1ps

module cartpole_euler_step (
   input  logic              clock,
   input  logic              reset,
   cpe_req_if.sink           req_if,
   cpe_rsp_if.source         rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  cpe_pkg::word_type csr_pwdata,
   output cpe_pkg::word_type csr_prdata,
   output logic              csr_pready
);
   import cpe_pkg::*;

   typedef enum logic [1:0] {
      REG_INIT_POSITION,
      REG_INIT_VELOCITY,
      REG_INIT_ANGLE,
      REG_INIT_ANGULAR_RATE
   } reg_index_type;

   init_type      init_ff, init_in;
   reg_index_type reg_idx;
   logic          csr_wr;

   seq_ctl_type ctl;
   logic        seq_idle, seq_done;
   result_type  seq_res;

   result_type  out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   // Register file: written on the access phase of an APB write.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      init_in = init_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_INIT_POSITION:     init_in.position     = csr_pwdata;
            REG_INIT_VELOCITY:     init_in.velocity     = csr_pwdata;
            REG_INIT_ANGLE:        init_in.angle        = csr_pwdata;
            REG_INIT_ANGULAR_RATE: init_in.angular_rate = csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INIT_POSITION:     csr_prdata = init_ff.position;
         REG_INIT_VELOCITY:     csr_prdata = init_ff.velocity;
         REG_INIT_ANGLE:        csr_prdata = init_ff.angle;
         REG_INIT_ANGULAR_RATE: csr_prdata = init_ff.angular_rate;
      endcase
   end

   // The sequencer hands its result to the output register when that register is empty
   // or is being emptied in the same cycle.
   assign req_if.ready = seq_idle;
   assign ctl.start    = req_if.valid && seq_idle;
   assign ctl.action   = req_if.action;
   assign ctl.take     = seq_done && (!out_valid_ff || rsp_if.ready);

   cpe_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .force_req (req_if.force_req),
      .init      (init_ff),
      .idle      (seq_idle),
      .done      (seq_done),
      .result    (seq_res)
   );

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (ctl.take) begin
         out_in       = seq_res;
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.position     = out_ff.position;
   assign rsp_if.velocity     = out_ff.velocity;
   assign rsp_if.angle        = out_ff.angle;
   assign rsp_if.angular_rate = out_ff.angular_rate;
   assign rsp_if.saturated    = out_ff.saturated;

endmodule

>>> sv/cpe_checker.sv
// Port-level assertions for the cart-pole step block, bound to the top level.
// Depends on cpe_pkg for the word type and on cartpole_euler_step.
`timescale 1ns / 1ps

module cpe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cpe_pkg::word_type rsp_position
);

   // A held response word stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
      else $error("response dropped or changed while stalled");

   // Once a request is taken the block is busy on the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A new response only appears after the block was busy.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work");

   // Reset leaves an idle block with no pending response.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind cartpole_euler_step cpe_checker u_cpe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_position (rsp_if.position)
);
